[src/sacr_pkg.sv]
// Shared constants, types and helpers for the set-associative cache.
// Used by sacr_tag_dir and set_assoc_cache_random_replace_core.
`timescale 1ns / 1ps

package sacr_pkg;

  // Geometry
  localparam int ADDRESS_BITS = 8;
  localparam int DATA_BITS    = 8;
  localparam int NUM_SETS     = 2;
  localparam int NUM_WAYS     = 4;
  localparam int LINE_WORDS   = 16;

  localparam int OFF_BITS  = $clog2(LINE_WORDS);
  localparam int SET_BITS  = $clog2(NUM_SETS);
  localparam int WAY_BITS  = $clog2(NUM_WAYS);
  localparam int TAG_BITS  = ADDRESS_BITS - OFF_BITS - SET_BITS;
  localparam int LINE_ADDR_BITS = SET_BITS + WAY_BITS + OFF_BITS;

  // Victim LFSR: Galois form, maximal length
  localparam int              LFSR_BITS = 8;
  localparam logic [LFSR_BITS-1:0] LFSR_SEED = 8'h01;
  localparam logic [LFSR_BITS-1:0] LFSR_TAPS = 8'hB8;

  // Result of a tag lookup
  typedef struct packed {
    logic                hit;
    logic [WAY_BITS-1:0] hit_way;
    logic [WAY_BITS-1:0] victim;
  } lookup_t;

  // Directory update request
  typedef struct packed {
    logic                pick;
    logic                alloc;
    logic [WAY_BITS-1:0] way;
  } dir_cmd_t;

  // Advance the LFSR by one step
  function automatic logic [LFSR_BITS-1:0] lfsr_next(input logic [LFSR_BITS-1:0] s);
    logic [LFSR_BITS-1:0] n;
    n = s >> 1;
    if (s[0]) n = n ^ LFSR_TAPS;
    return n;
  endfunction

endpackage

[src/sacr_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module sacr_ram #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // Write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[src/sacr_tag_dir.sv]
// Tag directory: per-way tags and valid bits, parallel compare, victim LFSR.
// Depends on sacr_pkg.
`timescale 1ns / 1ps

module sacr_tag_dir (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [sacr_pkg::SET_BITS-1:0]   look_set,
  input  logic [sacr_pkg::TAG_BITS-1:0]   look_tag,
  input  sacr_pkg::dir_cmd_t              cmd,
  output sacr_pkg::lookup_t               look
);

  logic [sacr_pkg::TAG_BITS-1:0]  tags  [sacr_pkg::NUM_WAYS][sacr_pkg::NUM_SETS];
  logic [sacr_pkg::NUM_WAYS-1:0]  valid [sacr_pkg::NUM_SETS];
  logic [sacr_pkg::LFSR_BITS-1:0] lfsr;
  logic [sacr_pkg::LFSR_BITS-1:0] lfsr_adv;
  logic [sacr_pkg::WAY_BITS-1:0]  free_way;
  logic                           all_valid;

  // Compare all ways of the set; lowest match and lowest free way win
  always_comb begin
    look.hit     = 1'b0;
    look.hit_way = '0;
    free_way     = '0;
    for (int w = sacr_pkg::NUM_WAYS - 1; w >= 0; w--) begin
      if (valid[look_set][w] && (tags[w][look_set] == look_tag)) begin
        look.hit     = 1'b1;
        look.hit_way = sacr_pkg::WAY_BITS'(w);
      end
      if (!valid[look_set][w]) free_way = sacr_pkg::WAY_BITS'(w);
    end
    all_valid   = &valid[look_set];
    lfsr_adv    = sacr_pkg::lfsr_next(lfsr);
    look.victim = all_valid ? lfsr_adv[sacr_pkg::WAY_BITS-1:0] : free_way;
  end

  // Valid bits and LFSR
  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= sacr_pkg::LFSR_SEED;
      for (int s = 0; s < sacr_pkg::NUM_SETS; s++) valid[s] <= '0;
    end else begin
      if (cmd.pick && all_valid) lfsr <= lfsr_adv;
      if (cmd.alloc) valid[look_set][cmd.way] <= 1'b1;
    end
  end

  // Tag storage
  always_ff @(posedge clk) begin
    if (cmd.alloc) tags[cmd.way][look_set] <= look_tag;
  end

endmodule

[src/set_assoc_cache_random_replace_core.sv]
// Top level of the set-associative cache with random replacement.
// Depends on sacr_pkg, sacr_ram and sacr_tag_dir.
`timescale 1ns / 1ps

// A 2-set, 4-way cache with 16-word lines in front of a 256-word backing store.
// One access is taken at a time. A write passes from lookup to the done state,
// a read hit through lookup and a line read, and a read miss through lookup and
// the line fill, which reads the backing RAM one word per cycle through its single
// read port. After reset the block runs a clearing pass over the backing RAM,
// holding in_stall high. A finished result sits in the output register, and the
// next input transfer is taken while it waits.
module set_assoc_cache_random_replace_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               kind,
  input  logic [sacr_pkg::ADDRESS_BITS-1:0]  address,
  input  logic [sacr_pkg::DATA_BITS-1:0]     write_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [sacr_pkg::DATA_BITS-1:0]     read_data,
  output logic                               hit
);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_LOOKUP = 6'b000100,
    S_RDATA  = 6'b001000,
    S_FILL   = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [sacr_pkg::ADDRESS_BITS-1:0] clr_cnt;
  logic [sacr_pkg::OFF_BITS:0]       cnt;
  logic                              req_kind;
  logic [sacr_pkg::ADDRESS_BITS-1:0] req_addr;
  logic [sacr_pkg::DATA_BITS-1:0]    req_data;
  logic [sacr_pkg::WAY_BITS-1:0]     victim;
  logic [sacr_pkg::DATA_BITS-1:0]    res_data;
  logic                              res_hit;

  logic [sacr_pkg::OFF_BITS-1:0] req_off;
  logic [sacr_pkg::SET_BITS-1:0] req_set;
  logic [sacr_pkg::TAG_BITS-1:0] req_tag;
  logic [sacr_pkg::OFF_BITS-1:0] fill_off;

  logic                                bk_we;
  logic [sacr_pkg::ADDRESS_BITS-1:0]   bk_waddr;
  logic [sacr_pkg::DATA_BITS-1:0]      bk_wdata;
  logic [sacr_pkg::ADDRESS_BITS-1:0]   bk_raddr;
  logic [sacr_pkg::DATA_BITS-1:0]      bk_rdata;
  logic                                ln_we;
  logic [sacr_pkg::LINE_ADDR_BITS-1:0] ln_waddr;
  logic [sacr_pkg::DATA_BITS-1:0]      ln_wdata;
  logic [sacr_pkg::LINE_ADDR_BITS-1:0] ln_raddr;
  logic [sacr_pkg::DATA_BITS-1:0]      ln_rdata;

  sacr_pkg::lookup_t  look;
  sacr_pkg::dir_cmd_t dir_cmd;

  logic in_xfer;
  logic done_go;
  logic fill_wr;

  assign req_off  = req_addr[sacr_pkg::OFF_BITS-1:0];
  assign req_set  = req_addr[sacr_pkg::OFF_BITS +: sacr_pkg::SET_BITS];
  assign req_tag  = req_addr[sacr_pkg::ADDRESS_BITS-1 -: sacr_pkg::TAG_BITS];
  assign fill_off = sacr_pkg::OFF_BITS'(cnt - 1'b1);

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign done_go  = (state == S_DONE) && (!out_valid || !out_stall);
  assign fill_wr  = (state == S_FILL) && (cnt != '0);

  // Backing store and line data
  sacr_ram #(
    .ADDR_W (sacr_pkg::ADDRESS_BITS),
    .DATA_W (sacr_pkg::DATA_BITS)
  ) u_backing (
    .clk   (clk),
    .we    (bk_we),
    .waddr (bk_waddr),
    .wdata (bk_wdata),
    .raddr (bk_raddr),
    .rdata (bk_rdata)
  );

  sacr_ram #(
    .ADDR_W (sacr_pkg::LINE_ADDR_BITS),
    .DATA_W (sacr_pkg::DATA_BITS)
  ) u_lines (
    .clk   (clk),
    .we    (ln_we),
    .waddr (ln_waddr),
    .wdata (ln_wdata),
    .raddr (ln_raddr),
    .rdata (ln_rdata)
  );

  sacr_tag_dir u_dir (
    .clk      (clk),
    .rst      (rst),
    .look_set (req_set),
    .look_tag (req_tag),
    .cmd      (dir_cmd),
    .look     (look)
  );

  // Drive memory ports and directory updates
  always_comb begin
    bk_we    = 1'b0;
    bk_waddr = req_addr;
    bk_wdata = req_data;
    bk_raddr = {req_tag, req_set, cnt[sacr_pkg::OFF_BITS-1:0]};
    ln_we    = 1'b0;
    ln_waddr = {req_set, look.hit_way, req_off};
    ln_wdata = req_data;
    ln_raddr = {req_set, look.hit_way, req_off};
    dir_cmd  = '{pick: 1'b0, alloc: 1'b0, way: victim};
    unique case (state)
      S_CLEAR: begin
        bk_we    = 1'b1;
        bk_waddr = clr_cnt;
        bk_wdata = '0;
      end
      S_LOOKUP: begin
        if (req_kind) begin
          bk_we = 1'b1;
          ln_we = look.hit;
        end else if (!look.hit) begin
          dir_cmd.pick = 1'b1;
        end
      end
      S_FILL: begin
        ln_we    = fill_wr;
        ln_waddr = {req_set, victim, fill_off};
        ln_wdata = bk_rdata;
        dir_cmd.alloc = (cnt == (sacr_pkg::OFF_BITS + 1)'(sacr_pkg::LINE_WORDS));
      end
      default: ;
    endcase
  end

  // Sequence one access
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (clr_cnt == '1) state_next = S_IDLE;
      S_IDLE:   if (in_xfer) state_next = S_LOOKUP;
      S_LOOKUP: begin
        if (req_kind)      state_next = S_DONE;
        else if (look.hit) state_next = S_RDATA;
        else               state_next = S_FILL;
      end
      S_RDATA:  state_next = S_DONE;
      S_FILL:   if (dir_cmd.alloc) state_next = S_DONE;
      S_DONE:   if (done_go) state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      cnt     <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (state == S_FILL)  cnt <= cnt + 1'b1;
      else                  cnt <= '0;
    end
  end

  // Hold the request and build the result
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_kind <= kind;
      req_addr <= address;
      req_data <= write_data;
    end
    if (state == S_LOOKUP) begin
      victim   <= look.victim;
      res_hit  <= look.hit;
      res_data <= '0;
    end
    if (state == S_RDATA) res_data <= ln_rdata;
    if (fill_wr && (fill_off == req_off)) res_data <= bk_rdata;
  end

  // Output register: load when empty or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_go) begin
      read_data <= res_data;
      hit       <= res_hit;
    end
  end

endmodule

[tb/cache_access_checker.sv]
// Watches both channels of the set-associative cache, predicts each response
// from its own copy of memory, directory and victim LFSR, and compares. Depends on sacr_pkg.
`timescale 1ns / 1ps

module cache_access_checker
  import sacr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic                    kind,
  input  logic [ADDRESS_BITS-1:0] address,
  input  logic [DATA_BITS-1:0]    write_data,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [DATA_BITS-1:0]    read_data,
  input  logic                    hit,
  output int                      mismatch_count,
  output int                      outstanding
);

  typedef enum logic {ACCESS_READ = 1'b0, ACCESS_WRITE = 1'b1} access_t;

  localparam int NUM_LINES = NUM_SETS * NUM_WAYS;
  localparam int MEM_WORDS = 1 << ADDRESS_BITS;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [DATA_BITS-1:0] word;
    logic                 present;
  } response_t;

  // Shadow state of the cache and its backing store
  logic [DATA_BITS-1:0] backing_words [MEM_WORDS];
  logic [TAG_BITS-1:0]  line_tag      [NUM_LINES];
  logic                 line_valid    [NUM_LINES];
  logic [DATA_BITS-1:0] line_data     [NUM_LINES][LINE_WORDS];
  logic [LFSR_BITS-1:0] victim_lfsr;

  response_t awaited_responses [$];

  // Apply one access to the shadow state and return the response it causes
  task automatic predict_access(input logic op, input logic [ADDRESS_BITS-1:0] addr,
                                input logic [DATA_BITS-1:0] data, output response_t res);
    int base;
    int way;
    int victim;
    int line_base;
    int k;
    logic [OFF_BITS-1:0] offset;
    logic [TAG_BITS-1:0] tag;
    logic lsb;
    offset = addr[OFF_BITS-1:0];
    tag = addr[ADDRESS_BITS-1 -: TAG_BITS];
    base = int'(addr[OFF_BITS +: SET_BITS]) * NUM_WAYS;
    line_base = int'({addr[ADDRESS_BITS-1:OFF_BITS], {OFF_BITS{1'b0}}});
    way = -1;
    for (k = 0; k < NUM_WAYS; k++) begin
      if (way < 0 && line_valid[base + k] && line_tag[base + k] == tag) way = k;
    end
    res.present = (way >= 0);
    res.word = '0;
    if (op == ACCESS_WRITE) begin
      // Write through; update the cached copy only on a hit
      backing_words[addr] = data;
      if (way >= 0) line_data[base + way][offset] = data;
    end else if (way >= 0) begin
      res.word = line_data[base + way][offset];
    end else begin
      // Miss: lowest free way, else step the LFSR for a victim
      victim = -1;
      for (k = 0; k < NUM_WAYS; k++) begin
        if (victim < 0 && !line_valid[base + k]) victim = k;
      end
      if (victim < 0) begin
        lsb = victim_lfsr[0];
        victim_lfsr = victim_lfsr >> 1;
        if (lsb) victim_lfsr = victim_lfsr ^ LFSR_TAPS;
        victim = int'(victim_lfsr) % NUM_WAYS;
      end
      for (k = 0; k < LINE_WORDS; k++) begin
        line_data[base + victim][k] = backing_words[line_base + k];
      end
      line_tag[base + victim] = tag;
      line_valid[base + victim] = 1'b1;
      res.word = line_data[base + victim][offset];
    end
  endtask

  task automatic report_mismatch(input string field, input logic [DATA_BITS-1:0] want,
                                 input logic [DATA_BITS-1:0] got);
    if (mismatch_count < REPORT_LIMIT)
      $display("%0t: %s differs: expected %0h, got %0h", $realtime, field, want, got);
    mismatch_count++;
  endtask

  // Track transfers on both channels
  always @(posedge clk) begin
    response_t want;
    response_t next_res;
    if (rst) begin
      for (int a = 0; a < MEM_WORDS; a++) backing_words[a] = '0;
      for (int l = 0; l < NUM_LINES; l++) begin
        line_tag[l] = '0;
        line_valid[l] = 1'b0;
        for (int w = 0; w < LINE_WORDS; w++) line_data[l][w] = '0;
      end
      victim_lfsr = LFSR_SEED;
      awaited_responses.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_responses.size() == 0) begin
          if (mismatch_count < REPORT_LIMIT)
            $display("%0t: response with none awaited: data %0h hit %0b",
                     $realtime, read_data, hit);
          mismatch_count++;
        end else begin
          want = awaited_responses.pop_front();
          if (read_data !== want.word) report_mismatch("read_data", want.word, read_data);
          if (hit !== want.present)
            report_mismatch("hit", DATA_BITS'(want.present), DATA_BITS'(hit));
        end
      end
      if (in_valid && !in_stall) begin
        predict_access(kind, address, write_data, next_res);
        awaited_responses.push_back(next_res);
      end
    end
    outstanding <= awaited_responses.size();
  end

endmodule

[tb/set_assoc_cache_random_replace_core_tb.sv]
// Stimulus and verdict for the set-associative cache with random replacement.
// Depends on sacr_pkg, cache_access_checker and the block itself.
`timescale 1ns / 1ps

module set_assoc_cache_random_replace_core_tb;
  import sacr_pkg::*;

  typedef enum logic {ACCESS_READ = 1'b0, ACCESS_WRITE = 1'b1} access_t;

  localparam int RANDOM_ITEMS = 1550;
  localparam int SETTLE_CYCLES = 60;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    kind = 1'b0;
  logic [ADDRESS_BITS-1:0] address = '0;
  logic [DATA_BITS-1:0]    write_data = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [DATA_BITS-1:0]    read_data;
  logic                    hit;
  int                      mismatch_count;
  int                      outstanding;

  int burst_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int stall_phase = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  set_assoc_cache_random_replace_core u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .address    (address),
    .write_data (write_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_data  (read_data),
    .hit        (hit)
  );

  cache_access_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .kind           (kind),
    .address        (address),
    .write_data     (write_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .read_data      (read_data),
    .hit            (hit),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  // Present one access, hold it until transfer, then maybe idle between bursts
  task automatic issue(input access_t op, input logic [ADDRESS_BITS-1:0] addr,
                       input logic [DATA_BITS-1:0] data);
    int gap;
    kind <= op;
    address <= addr;
    write_data <= data;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
  endtask

  // Hold off the sender until every awaited response has come back
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Receiver back-pressure: switch between a few stall patterns
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(40, 300);
      end else begin
        mode_left--;
      end
      stall_phase++;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 99) < 25);
        2: out_stall <= ($urandom_range(0, 99) < 60);
        default: out_stall <= ((stall_phase % 11) < 4);
      endcase
    end
  end

  // Stimulus: directed corners, then random traffic
  initial begin
    logic [ADDRESS_BITS-1:0] addr;
    access_t op;
    rst <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Cold miss, write hit, read back
    issue(ACCESS_READ, 8'h00, 8'hFF);
    issue(ACCESS_WRITE, 8'h00, 8'hFF);
    issue(ACCESS_READ, 8'h00, 8'h00);
    // Top address: write miss, read miss fills the line, then hits
    issue(ACCESS_WRITE, 8'hFF, 8'hA5);
    issue(ACCESS_READ, 8'hFF, 8'h00);
    issue(ACCESS_READ, 8'hF0, 8'hFF);
    issue(ACCESS_WRITE, 8'hFF, 8'h00);
    issue(ACCESS_READ, 8'hFF, 8'h5A);
    // Write miss lands in memory only, then a fill picks it up
    issue(ACCESS_WRITE, 8'h25, 8'h5A);
    issue(ACCESS_READ, 8'h20, 8'h00);
    issue(ACCESS_READ, 8'h25, 8'h00);
    // Fill the remaining ways of set 0, then force LFSR victims
    issue(ACCESS_READ, 8'h40, 8'h00);
    issue(ACCESS_READ, 8'h60, 8'h00);
    issue(ACCESS_READ, 8'h80, 8'h00);
    issue(ACCESS_READ, 8'hA0, 8'h00);
    issue(ACCESS_READ, 8'hC0, 8'h00);
    issue(ACCESS_READ, 8'hE0, 8'h00);
    issue(ACCESS_READ, 8'h00, 8'h00);
    issue(ACCESS_WRITE, 8'h81, 8'h3C);
    issue(ACCESS_READ, 8'h81, 8'h00);
    issue(ACCESS_WRITE, 8'h7F, 8'hC3);
    issue(ACCESS_READ, 8'h70, 8'h00);
    issue(ACCESS_READ, 8'h7F, 8'h00);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) drain();
      op = ($urandom_range(0, 99) < 35) ? ACCESS_WRITE : ACCESS_READ;
      addr = ADDRESS_BITS'($urandom_range(0, (1 << ADDRESS_BITS) - 1));
      // Crowd a few tags so hits and evictions both stay frequent
      if ($urandom_range(0, 99) < 45)
        addr[ADDRESS_BITS-1 -: TAG_BITS] = TAG_BITS'($urandom_range(0, NUM_WAYS));
      issue(op, addr, DATA_BITS'($urandom_range(0, (1 << DATA_BITS) - 1)));
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog on the whole run
  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
